// ----- rtl/dac_command_frame_builder_top_defines.svh -----
// assertion macros for the dac command frame builder
`ifndef DAC_COMMAND_FRAME_BUILDER_TOP_DEFINES_SVH
`define DAC_COMMAND_FRAME_BUILDER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define DCFB_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dcfb check failed");

// next-cycle implication, sampled on clk, off during reset
`define DCFB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dcfb check failed");

`endif

// ----- rtl/dcfb_pkg.sv -----
// types, command codes and span tables for the dac command frame builder
package dcfb_pkg;

	localparam int CHANNELS_DEF = 16;
	localparam int KIND_W = 3;
	localparam int CH_W = 5;
	localparam int SPAN_W = 3;
	localparam int VOLT_W = 24;
	localparam int REF_W = 2;
	localparam int ECHO_W = 24;
	localparam int CMD_W = 8;
	localparam int CODE_W = 16;
	localparam int STAT_W = 2;
	localparam int X_W = 21;
	localparam int M_W = 38;
	localparam int QIN_W = 19;
	localparam int RECIP_W = 22;
	localparam int RECIP_SHIFT = 24;
	localparam int PROD_W = QIN_W + RECIP_W;
	localparam int SCL_W = 2;

	localparam logic [RECIP_W-1:0] RECIP_DIV5 = 22'd3355444;

	localparam logic [SPAN_W-1:0] SPAN_MAX = 3'd4;
	localparam logic [REF_W-1:0] REF_MAX = 2'd1;

	// full scale width of a span
	localparam logic [SCL_W-1:0] SCL_5V = 2'd0;
	localparam logic [SCL_W-1:0] SCL_10V = 2'd1;
	localparam logic [SCL_W-1:0] SCL_20V = 2'd2;

	localparam logic [CMD_W-1:0] CMD_UPDATE_N = 8'h10;
	localparam logic [CMD_W-1:0] CMD_WRITE_UPD_N = 8'h30;
	localparam logic [CMD_W-1:0] CMD_PDOWN_N = 8'h40;
	localparam logic [CMD_W-1:0] CMD_PDOWN_ALL = 8'h50;
	localparam logic [CMD_W-1:0] CMD_SPAN_N = 8'h60;
	localparam logic [CMD_W-1:0] CMD_CONFIG = 8'h70;
	localparam logic [CMD_W-1:0] CMD_UPDATE_ALL = 8'h90;
	localparam logic [CMD_W-1:0] CMD_WRITE_UPD_ALL = 8'hA0;
	localparam logic [CMD_W-1:0] CMD_SPAN_ALL = 8'hE0;

	typedef enum logic [KIND_W-1:0] {
		KIND_SPAN = 3'd0,
		KIND_VOLT = 3'd1,
		KIND_REF = 3'd2,
		KIND_PUP = 3'd3,
		KIND_PDOWN = 3'd4
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK = 2'd0,
		ST_BAD_SPAN = 2'd1,
		ST_BAD_REF = 2'd2,
		ST_SPAN_DIFF = 2'd3
	} status_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CH_W-1:0] channel;
		logic [SPAN_W-1:0] span;
		logic signed [VOLT_W-1:0] voltage;
		logic [REF_W-1:0] ref_mode;
		logic [ECHO_W-1:0] echo_word;
	} dcfb_cmd_t;

	typedef struct packed {
		logic send;
		logic [CMD_W-1:0] cmd_byte;
		status_t status;
		logic is_volt;
		logic [CODE_W-1:0] data_fix;
		logic [QIN_W-1:0] quo_in;
		logic [ECHO_W-1:0] echo;
	} dcfb_pay_t;

	typedef struct packed {
		logic valid;
		dcfb_pay_t pay;
	} dcfb_mid_t;

	// span limits in q7.16 volts
	function automatic logic signed [VOLT_W-1:0] span_lo_f(input logic [SPAN_W-1:0] sp);
		logic signed [VOLT_W-1:0] r;
		case (sp)
			3'd2: r = -24'sd327680;
			3'd3: r = -24'sd655360;
			3'd4: r = -24'sd163840;
			default: r = 24'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [VOLT_W-1:0] span_hi_f(input logic [SPAN_W-1:0] sp);
		logic signed [VOLT_W-1:0] r;
		case (sp)
			3'd1: r = 24'sd655360;
			3'd3: r = 24'sd655360;
			3'd4: r = 24'sd163840;
			default: r = 24'sd327680;
		endcase
		return r;
	endfunction

	// five, ten or twenty volt wide spans
	function automatic logic [SCL_W-1:0] span_scale_f(input logic [SPAN_W-1:0] sp);
		logic [SCL_W-1:0] r;
		case (sp)
			3'd1: r = SCL_10V;
			3'd2: r = SCL_10V;
			3'd3: r = SCL_20V;
			default: r = SCL_5V;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/dcfb_cmd_if.sv -----
// request channel carrying one dac command
interface dcfb_cmd_if import dcfb_pkg::*;;
	logic valid;
	logic ready;
	logic [KIND_W-1:0] kind;
	logic [CH_W-1:0] channel;
	logic [SPAN_W-1:0] span;
	logic signed [VOLT_W-1:0] voltage;
	logic [REF_W-1:0] ref_mode;
	logic [ECHO_W-1:0] echo_word;

	modport source (output valid, kind, channel, span, voltage, ref_mode, echo_word,
		input ready);
	modport sink (input valid, kind, channel, span, voltage, ref_mode, echo_word,
		output ready);
endinterface

// ----- rtl/dcfb_frame_if.sv -----
// result channel carrying one frame and its status
interface dcfb_frame_if import dcfb_pkg::*;;
	logic valid;
	logic ready;
	logic frame_valid;
	logic [CMD_W-1:0] command_byte;
	logic [CODE_W-1:0] data_code;
	logic [STAT_W-1:0] status;
	logic echo_ok;

	modport source (output valid, frame_valid, command_byte, data_code, status, echo_ok,
		input ready);
	modport sink (input valid, frame_valid, command_byte, data_code, status, echo_ok,
		output ready);
endinterface

// ----- rtl/dcfb_span_stage.sv -----
// input register, span store, command decode and voltage scaling front end
module dcfb_span_stage import dcfb_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input logic clk,
	input logic arst_n,
	dcfb_cmd_if.sink cmd,
	output dcfb_mid_t mid,
	input logic mid_ready
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [CH_W-1:0] CH_LIM = CH_W'(CHANNELS);

	logic valid_s1;
	dcfb_cmd_t cmd_s1;
	logic valid_s2;
	dcfb_pay_t pay_s2;
	logic [SPAN_W-1:0] span_store_q [CHANNELS];

	logic s1_ready;
	logic s2_ready;
	logic s1_move;
	logic single;
	logic [IDX_W-1:0] idx;
	logic [3:0] addr;
	logic [SPAN_W-1:0] sp_cur;
	logic all_eq;
	logic span_wr;
	logic signed [VOLT_W-1:0] lo;
	logic signed [VOLT_W-1:0] hi;
	logic signed [VOLT_W-1:0] vc;
	logic signed [VOLT_W-1:0] diff;
	logic [SCL_W-1:0] scale;
	logic [X_W-1:0] x;
	logic [X_W-1:0] den_m1;
	logic [M_W-1:0] m;
	logic [QIN_W-1:0] quo_in;
	dcfb_pay_t pay_d;

	assign s2_ready = !valid_s2 || mid_ready;
	assign s1_ready = !valid_s1 || s2_ready;
	assign s1_move = valid_s1 && s2_ready;
	assign cmd.ready = s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && s1_ready) begin
			cmd_s1 <= '{kind: cmd.kind, channel: cmd.channel, span: cmd.span,
				voltage: cmd.voltage, ref_mode: cmd.ref_mode, echo_word: cmd.echo_word};
		end
	end

	assign single = cmd_s1.channel < CH_LIM;
	assign idx = single ? cmd_s1.channel[IDX_W-1:0] : '0;
	assign addr = single ? cmd_s1.channel[3:0] : 4'h0;
	assign sp_cur = span_store_q[idx];

	always_comb begin
		all_eq = 1'b1;
		for (int i = 1; i < CHANNELS; i++) begin
			if (span_store_q[i] != span_store_q[0]) begin
				all_eq = 1'b0;
			end
		end
	end

	// clamp, then 2*65535*x + den - 1 shifted down by the power-of-two part of 2*den
	always_comb begin
		lo = span_lo_f(sp_cur);
		hi = span_hi_f(sp_cur);
		scale = span_scale_f(sp_cur);
		if (cmd_s1.voltage < lo) begin
			vc = lo;
		end else if (cmd_s1.voltage > hi) begin
			vc = hi;
		end else begin
			vc = cmd_s1.voltage;
		end
		diff = vc - lo;
		x = diff[X_W-1:0];
		case (scale)
			SCL_10V: den_m1 = 21'd655359;
			SCL_20V: den_m1 = 21'd1310719;
			default: den_m1 = 21'd327679;
		endcase
		m = {x, 17'b0} - {16'b0, x, 1'b0} + {17'b0, den_m1};
		case (scale)
			SCL_10V: quo_in = m[36:18];
			SCL_20V: quo_in = m[37:19];
			default: quo_in = m[35:17];
		endcase
	end

	always_comb begin
		pay_d = '0;
		pay_d.status = ST_OK;
		pay_d.echo = cmd_s1.echo_word;
		pay_d.quo_in = quo_in;
		span_wr = 1'b0;
		case (kind_t'(cmd_s1.kind))
			KIND_SPAN: begin
				if (cmd_s1.span > SPAN_MAX) begin
					pay_d.status = ST_BAD_SPAN;
				end else begin
					span_wr = 1'b1;
					pay_d.send = 1'b1;
					pay_d.cmd_byte = single ? (CMD_SPAN_N | {4'h0, addr}) : CMD_SPAN_ALL;
					pay_d.data_fix = {13'b0, cmd_s1.span};
				end
			end
			KIND_VOLT: begin
				if (!single && !all_eq) begin
					pay_d.status = ST_SPAN_DIFF;
				end else begin
					pay_d.send = 1'b1;
					pay_d.is_volt = 1'b1;
					pay_d.cmd_byte = single ? (CMD_WRITE_UPD_N | {4'h0, addr})
						: CMD_WRITE_UPD_ALL;
				end
			end
			KIND_REF: begin
				if (cmd_s1.ref_mode > REF_MAX) begin
					pay_d.status = ST_BAD_REF;
				end else begin
					pay_d.send = 1'b1;
					pay_d.cmd_byte = CMD_CONFIG;
					pay_d.data_fix = {14'b0, cmd_s1.ref_mode};
				end
			end
			KIND_PUP: begin
				pay_d.send = 1'b1;
				pay_d.cmd_byte = single ? (CMD_UPDATE_N | {4'h0, addr}) : CMD_UPDATE_ALL;
			end
			KIND_PDOWN: begin
				pay_d.send = 1'b1;
				pay_d.cmd_byte = single ? (CMD_PDOWN_N | {4'h0, addr}) : CMD_PDOWN_ALL;
			end
			default: begin
				pay_d.send = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				span_store_q[i] <= '0;
			end
		end else if (s1_move && span_wr) begin
			if (single) begin
				span_store_q[idx] <= cmd_s1.span;
			end else begin
				for (int i = 0; i < CHANNELS; i++) begin
					span_store_q[i] <= cmd_s1.span;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			pay_s2 <= pay_d;
		end
	end

	assign mid = '{valid: valid_s2, pay: pay_s2};

endmodule

// ----- rtl/dcfb_frame_stage.sv -----
// divide by five, echo check, last frame tracking and result register
module dcfb_frame_stage import dcfb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input dcfb_mid_t mid,
	output logic mid_ready,
	dcfb_frame_if.source frame
);

	logic valid_s3;
	logic frame_valid_s3;
	logic [CMD_W-1:0] cmd_s3;
	logic [CODE_W-1:0] data_s3;
	logic [STAT_W-1:0] status_s3;
	logic echo_ok_s3;
	logic [ECHO_W-1:0] last_frame_q;

	logic move;
	logic [PROD_W-1:0] prod;
	logic [CODE_W-1:0] code;
	logic [CODE_W-1:0] data;
	logic eok;

	assign mid_ready = !valid_s3 || frame.ready;
	assign move = mid.valid && mid_ready;

	assign prod = PROD_W'(mid.pay.quo_in) * PROD_W'(RECIP_DIV5);
	assign code = prod[RECIP_SHIFT+CODE_W-1:RECIP_SHIFT];
	assign data = !mid.pay.send ? '0 : (mid.pay.is_volt ? code : mid.pay.data_fix);
	assign eok = mid.pay.send && (mid.pay.echo == last_frame_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			last_frame_q <= '0;
		end else begin
			if (mid_ready) begin
				valid_s3 <= mid.valid;
			end
			if (move && mid.pay.send) begin
				last_frame_q <= {8'h00, mid.pay.cmd_byte, data[15:8]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			frame_valid_s3 <= mid.pay.send;
			cmd_s3 <= mid.pay.send ? mid.pay.cmd_byte : '0;
			data_s3 <= data;
			status_s3 <= mid.pay.status;
			echo_ok_s3 <= eok;
		end
	end

	assign frame.valid = valid_s3;
	assign frame.frame_valid = frame_valid_s3;
	assign frame.command_byte = cmd_s3;
	assign frame.data_code = data_s3;
	assign frame.status = status_s3;
	assign frame.echo_ok = echo_ok_s3;

endmodule

// ----- rtl/dac_command_frame_builder_top.sv -----
// dac command frame builder: 16-channel span, voltage, reference and power commands
// usage
//   cmd channel takes one request per cycle while cmd ready is high: kind,
//   channel (16 and up = all), span, q7.16 voltage, reference mode and the echo bytes of this transfer
//   frame channel returns exactly one result per request: frame_valid, the
//   command byte, the 16-bit data word, status and the echo match flag
//   result is registered in the divide/result stage; a new
//   request is taken every cycle when the frame side keeps ready high
//   the three register stages are input, decode/scale, and divide/result;
//   the divide by five multiply sits alone in the last stage
//   span changes take effect for the very next request
//   when the frame side stalls, the result holds and earlier stages keep
//   filling until all three are full, then cmd ready drops
//   reset clears all spans to code 0 and the last sent frame to zero, and
//   empties the pipeline
`include "dac_command_frame_builder_top_defines.svh"

module dac_command_frame_builder_top import dcfb_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input logic clk,
	input logic arst_n,
	dcfb_cmd_if.sink cmd,
	dcfb_frame_if.source frame
);

	dcfb_mid_t mid;
	logic mid_ready;

	dcfb_span_stage #(
		.CHANNELS(CHANNELS)
	) u_span_stage (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.mid(mid),
		.mid_ready(mid_ready)
	);

	dcfb_frame_stage u_frame_stage (
		.clk(clk),
		.arst_n(arst_n),
		.mid(mid),
		.mid_ready(mid_ready),
		.frame(frame)
	);

	`DCFB_ASSERT_IMPL(a_err_no_frame, frame.valid && (frame.status != ST_OK), !frame.frame_valid && (frame.command_byte == '0) && (frame.data_code == '0) && !frame.echo_ok)
	`DCFB_ASSERT_IMPL(a_frame_has_cmd, frame.valid && frame.frame_valid, (frame.command_byte[7:4] != 4'h0) && (frame.status == ST_OK))
	`DCFB_ASSERT_NEXT(a_mid_held, mid.valid && !mid_ready, mid.valid)

endmodule
